/* design/lpsd_pkg.sv */
// Shared types and constants for the length-prefixed string deframer.
// No dependencies; used by lpsd_core, lpsd_out_stage and the top level.
`default_nettype none

package lpsd_pkg;

  localparam logic [7:0] MARKER_STRING = 8'd11;
  localparam int         LEB_VALUE_W   = 7;
  localparam int         LEB_CONT_IDX  = 7;
  localparam int         OUT_LEN_W     = 32;

  localparam logic [1:0] KIND_NULL  = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           payload;
    logic                 last;
    logic [OUT_LEN_W-1:0] announced_length;
  } result_t;

endpackage

`default_nettype wire

/* design/lpsd_core.sv */
// Field parser: marker, ULEB128 length prefix and payload countdown.
// Depends on lpsd_pkg; produces at most one result per accepted byte.
`default_nettype none

module lpsd_core #(
  parameter int MAX_LEN_BYTES = 16,
  parameter int LEN_WIDTH     = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [7:0]       data_byte,
  output logic                  res_valid,
  output lpsd_pkg::result_t     res
);

  localparam int CNT_W   = $clog2(MAX_LEN_BYTES + 1);
  localparam int SHIFT_W = $clog2(lpsd_pkg::LEB_VALUE_W * MAX_LEN_BYTES);

  typedef enum logic [1:0] {
    PH_MARKER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [LEN_WIDTH-1:0] accum_r, accum_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [LEN_WIDTH-1:0] remain_r, remain_nxt;

  logic [SHIFT_W-1:0]   shift;
  logic [LEN_WIDTH-1:0] part;
  logic [LEN_WIDTH-1:0] accum_upd;
  logic [CNT_W-1:0]     count_inc;
  logic                 fin;

  assign shift     = SHIFT_W'(lpsd_pkg::LEB_VALUE_W) * SHIFT_W'(count_r);
  assign part      = (32'(shift) < 32'(LEN_WIDTH))
                     ? (LEN_WIDTH'(data_byte[lpsd_pkg::LEB_VALUE_W-1:0]) << shift)
                     : '0;
  assign accum_upd = accum_r | part;
  assign count_inc = count_r + CNT_W'(1);
  assign fin       = (remain_r <= LEN_WIDTH'(1));

  always_comb begin
    phase_nxt  = phase_r;
    accum_nxt  = accum_r;
    count_nxt  = count_r;
    remain_nxt = remain_r;
    res_valid  = 1'b0;
    res        = '0;
    case (phase_r)
      PH_LENGTH: begin
        accum_nxt = accum_upd;
        count_nxt = count_inc;
        if (!data_byte[lpsd_pkg::LEB_CONT_IDX] ||
            32'(count_inc) >= 32'(MAX_LEN_BYTES)) begin
          count_nxt = '0;
          if (accum_upd == '0) begin
            phase_nxt      = PH_MARKER;
            res_valid      = 1'b1;
            res.kind       = lpsd_pkg::KIND_EMPTY;
            res.last       = 1'b1;
          end else begin
            remain_nxt = accum_upd;
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid            = 1'b1;
        res.kind             = lpsd_pkg::KIND_BYTE;
        res.payload          = data_byte;
        res.last             = fin;
        res.announced_length = lpsd_pkg::OUT_LEN_W'(accum_r);
        if (remain_r != '0) begin
          remain_nxt = remain_r - LEN_WIDTH'(1);
        end
        if (fin) begin
          phase_nxt = PH_MARKER;
        end
      end
      default: begin
        phase_nxt = PH_MARKER;
        if (data_byte != lpsd_pkg::MARKER_STRING) begin
          res_valid = 1'b1;
          res.kind  = lpsd_pkg::KIND_NULL;
          res.last  = 1'b1;
        end else begin
          accum_nxt  = '0;
          count_nxt  = '0;
          remain_nxt = '0;
          phase_nxt  = PH_LENGTH;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MARKER;
      accum_r  <= '0;
      count_r  <= '0;
      remain_r <= '0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != '0)
    else $error("payload phase with nothing remaining");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) < 32'(MAX_LEN_BYTES))
    else $error("length byte count out of range");

  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid && res.last) |=> phase_r == PH_MARKER)
    else $error("final result did not return to marker phase");

  a_length_no_count_leak: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == PH_MARKER) |=> count_r == '0)
    else $error("length byte count not cleared after marker");

endmodule

`default_nettype wire

/* design/lpsd_out_stage.sv */
// Result register with one skid entry between parser and output channel.
// Depends on lpsd_pkg for the result struct.
`default_nettype none

module lpsd_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire lpsd_pkg::result_t res,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lpsd_pkg::result_t      out_res
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  lpsd_pkg::result_t main_r, main_nxt;
  lpsd_pkg::result_t skid_r, skid_nxt;

  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = res_valid;
        skid_nxt       = res;
      end else begin
        main_valid_nxt = res_valid;
        main_nxt       = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without a result in front");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && main_valid_r && !out_ready) |-> !res_valid)
    else $error("result arrived with both entries full");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready && !res_valid) |=> !skid_valid_r && main_valid_r)
    else $error("skid entry did not advance");

endmodule

`default_nettype wire

/* design/leb128_prefixed_string_deframer.sv */
// Top level: length-prefixed string deframer (marker, ULEB128 length, payload).
// Depends on lpsd_pkg, lpsd_core and lpsd_out_stage.
//
//   channel | ports                                         | dir
//   input   | in_valid, in_ready, in_data_byte              | in
//   result  | out_valid, out_ready, out_kind, out_payload,  | out
//           | out_last, out_announced_length                |
//
// One input byte per cycle while in_ready is high; a result is registered and
// appears on the output from the result register, via the skid entry on a stall.
// Synchronous active-low reset returns the parser to marker phase and empties
// the result register and its skid entry.
// in_ready drops only while the skid entry is occupied, i.e. after the output
// has stalled with a result waiting and another result came in behind it.
`default_nettype none

module leb128_prefixed_string_deframer #(
  parameter int MAX_LEN_BYTES = 16,
  parameter int LEN_WIDTH     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload,
  output logic             out_last,
  output logic [31:0]      out_announced_length
);

  logic              in_fire;
  logic              core_valid;
  logic              space;
  lpsd_pkg::result_t core_res;
  lpsd_pkg::result_t out_res;

  assign in_ready = space;
  assign in_fire  = in_valid && space;

  lpsd_core #(
    .MAX_LEN_BYTES (MAX_LEN_BYTES),
    .LEN_WIDTH     (LEN_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .res_valid (core_valid),
    .res       (core_res)
  );

  lpsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (core_valid && in_fire),
    .res       (core_res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind             = out_res.kind;
  assign out_payload          = out_res.payload;
  assign out_last             = out_res.last;
  assign out_announced_length = out_res.announced_length;

endmodule

`default_nettype wire
